/* hw/rtl/ppp_pkg.sv */
// Shared constants and types for the pinhole point projection pipeline.
// Used by ppp_dot, ppp_div, ppp_sat and pinhole_point_projection; no dependencies.
`timescale 1ns / 1ps

package ppp_pkg;

    localparam int COEF_WIDTH_DEF  = 16;
    localparam int COORD_WIDTH_DEF = 16;

    localparam int ROW_WIDTH     = 64;
    localparam int NUM_ROWS      = 3;
    localparam int NUM_TERMS     = 4;
    localparam int PT_WIDTH      = 16;
    localparam int PIX_WIDTH     = 16;
    localparam int QBITS         = PIX_WIDTH + 1;
    localparam int CFG_IDX_WIDTH = 2;

    localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW_U = 2'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW_V = 2'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ROW_W = 2'd2;

    localparam logic [QBITS-1:0] Q_POS_LIMIT = QBITS'(2 ** (PIX_WIDTH - 1) - 1);
    localparam logic [QBITS-1:0] Q_NEG_LIMIT = QBITS'(2 ** (PIX_WIDTH - 1));

    localparam logic [PIX_WIDTH-1:0] PIX_MAX_VAL = {1'b0, {(PIX_WIDTH - 1){1'b1}}};
    localparam logic [PIX_WIDTH-1:0] PIX_MIN_VAL = {1'b1, {(PIX_WIDTH - 1){1'b0}}};

    typedef struct packed {
        logic ovf_u;
        logic ovf_v;
        logic neg_u;
        logic neg_v;
        logic zero;
    } ppp_div_status_t;

    typedef struct packed {
        logic saturated;
        logic depth_zero;
    } ppp_flags_t;

endpackage

/* hw/rtl/ppp_dot.sv */
// Three-stage dot product of one point with the three camera matrix rows.
// Depends on ppp_pkg for field and row widths.
`timescale 1ns / 1ps

module ppp_dot #(
    parameter int COEF_WIDTH  = ppp_pkg::COEF_WIDTH_DEF,
    parameter int COORD_WIDTH = ppp_pkg::COORD_WIDTH_DEF,
    parameter int SUM_WIDTH   = COEF_WIDTH + COORD_WIDTH + 2
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic [ppp_pkg::ROW_WIDTH-1:0]                 row_u,
    input  logic [ppp_pkg::ROW_WIDTH-1:0]                 row_v,
    input  logic [ppp_pkg::ROW_WIDTH-1:0]                 row_w,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  logic [ppp_pkg::NUM_TERMS*ppp_pkg::PT_WIDTH-1:0] point,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic signed [SUM_WIDTH-1:0]                   dot_a,
    output logic signed [SUM_WIDTH-1:0]                   dot_b,
    output logic signed [SUM_WIDTH-1:0]                   dot_c
);

    localparam int P  = COEF_WIDTH + COORD_WIDTH;
    localparam int NR = ppp_pkg::NUM_ROWS;
    localparam int NT = ppp_pkg::NUM_TERMS;

    logic [ppp_pkg::ROW_WIDTH-1:0] rows [NR];
    logic signed [P-1:0] coef_ext [NR][NT];
    logic signed [P-1:0] crd_ext [NT];
    logic signed [P-1:0] prod_next [NR][NT];

    logic signed [P-1:0]         prod_reg [NR][NT];
    logic signed [P:0]           pair_reg [NR][2];
    logic signed [SUM_WIDTH-1:0] sum_reg [NR];

    logic [2:0] valid_reg;
    logic [2:0] valid_next;
    logic [2:0] en;

    assign rows[0] = row_u;
    assign rows[1] = row_v;
    assign rows[2] = row_w;

    always_comb
    begin
        for (int k = 0; k < NT; k++)
        begin
            crd_ext[k] = P'(signed'(point[k*ppp_pkg::PT_WIDTH +: COORD_WIDTH]));
        end
        for (int r = 0; r < NR; r++)
        begin
            for (int k = 0; k < NT; k++)
            begin
                coef_ext[r][k]  = P'(signed'(rows[r][k*COEF_WIDTH +: COEF_WIDTH]));
                prod_next[r][k] = coef_ext[r][k] * crd_ext[k];
            end
        end
    end

    assign en[2]    = !valid_reg[2] || out_ready;
    assign en[1]    = !valid_reg[1] || en[2];
    assign en[0]    = !valid_reg[0] || en[1];
    assign in_ready = en[0];

    assign valid_next = {valid_reg[1:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= (en & valid_next) | (~en & valid_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        for (int r = 0; r < NR; r++)
        begin
            if (en[0])
            begin
                for (int k = 0; k < NT; k++)
                begin
                    prod_reg[r][k] <= prod_next[r][k];
                end
            end
            if (en[1])
            begin
                pair_reg[r][0] <= (P+1)'(prod_reg[r][0]) + (P+1)'(prod_reg[r][1]);
                pair_reg[r][1] <= (P+1)'(prod_reg[r][2]) + (P+1)'(prod_reg[r][3]);
            end
            if (en[2])
            begin
                sum_reg[r] <= SUM_WIDTH'(pair_reg[r][0]) + SUM_WIDTH'(pair_reg[r][1]);
            end
        end
    end

    assign out_valid = valid_reg[2];
    assign dot_a     = sum_reg[0];
    assign dot_b     = sum_reg[1];
    assign dot_c     = sum_reg[2];

endmodule

/* hw/rtl/ppp_div.sv */
// Pipelined restoring divider: round(a/c) and round(b/c), one quotient bit per stage.
// Depends on ppp_pkg for the quotient width and the status struct.
`timescale 1ns / 1ps

module ppp_div #(
    parameter int SUM_WIDTH = ppp_pkg::COEF_WIDTH_DEF + ppp_pkg::COORD_WIDTH_DEF + 2
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic signed [SUM_WIDTH-1:0]     dot_a,
    input  logic signed [SUM_WIDTH-1:0]     dot_b,
    input  logic signed [SUM_WIDTH-1:0]     dot_c,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ppp_pkg::QBITS-1:0]       quot_u,
    output logic [ppp_pkg::QBITS-1:0]       quot_v,
    output ppp_pkg::ppp_div_status_t        status
);

    localparam int S  = SUM_WIDTH;
    localparam int QB = ppp_pkg::QBITS;
    localparam int DW = S + 1;
    localparam int RW = S + 1 + QB;
    localparam int NS = QB + 2;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] valid_next;
    logic [NS-1:0] en;

    logic [S-1:0] a_u, b_u, c_u;
    logic [S-1:0] mag_a_reg, mag_b_reg, mag_c_reg;
    logic         neg_u_reg, neg_v_reg, zero_reg;

    logic [S+1:0] num_u, num_v;
    logic [DW-1:0] den;
    logic [RW-1:0] den_top;

    logic [RW-1:0]             rem_u_reg [QB+1];
    logic [RW-1:0]             rem_v_reg [QB+1];
    logic [QB-1:0]             q_u_reg [QB+1];
    logic [QB-1:0]             q_v_reg [QB+1];
    logic [DW-1:0]             den_reg [QB+1];
    ppp_pkg::ppp_div_status_t  status_reg [QB+1];

    assign en[NS-1] = !valid_reg[NS-1] || out_ready;
    for (genvar i = 0; i < NS - 1; i++)
    begin : g_en
        assign en[i] = !valid_reg[i] || en[i+1];
    end
    assign in_ready = en[0];

    assign valid_next = {valid_reg[NS-2:0], in_valid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= (en & valid_next) | (~en & valid_reg);
        end
    end

    assign a_u = dot_a;
    assign b_u = dot_b;
    assign c_u = dot_c;

    // Take magnitudes and signs
    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            mag_a_reg <= a_u[S-1] ? (~a_u + 1'b1) : a_u;
            mag_b_reg <= b_u[S-1] ? (~b_u + 1'b1) : b_u;
            mag_c_reg <= c_u[S-1] ? (~c_u + 1'b1) : c_u;
            neg_u_reg <= a_u[S-1] ^ c_u[S-1];
            neg_v_reg <= b_u[S-1] ^ c_u[S-1];
            zero_reg  <= (c_u == '0);
        end
    end

    // Form 2|n|+|d| over 2|d| and flag quotients beyond the bit range
    assign num_u   = {1'b0, mag_a_reg, 1'b0} + (S+2)'(mag_c_reg);
    assign num_v   = {1'b0, mag_b_reg, 1'b0} + (S+2)'(mag_c_reg);
    assign den     = {mag_c_reg, 1'b0};
    assign den_top = RW'(den) << QB;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            rem_u_reg[0]        <= RW'(num_u);
            rem_v_reg[0]        <= RW'(num_v);
            q_u_reg[0]          <= '0;
            q_v_reg[0]          <= '0;
            den_reg[0]          <= den;
            status_reg[0].ovf_u <= RW'(num_u) >= den_top;
            status_reg[0].ovf_v <= RW'(num_v) >= den_top;
            status_reg[0].neg_u <= neg_u_reg;
            status_reg[0].neg_v <= neg_v_reg;
            status_reg[0].zero  <= zero_reg;
        end
    end

    for (genvar j = 0; j < QB; j++)
    begin : g_iter
        localparam int BIT = QB - 1 - j;

        logic [RW-1:0] sub;
        logic          ge_u, ge_v;

        assign sub  = RW'(den_reg[j]) << BIT;
        assign ge_u = rem_u_reg[j] >= sub;
        assign ge_v = rem_v_reg[j] >= sub;

        always_ff @(posedge clk)
        begin
            if (en[j+2])
            begin
                rem_u_reg[j+1]  <= ge_u ? rem_u_reg[j] - sub : rem_u_reg[j];
                rem_v_reg[j+1]  <= ge_v ? rem_v_reg[j] - sub : rem_v_reg[j];
                q_u_reg[j+1]    <= q_u_reg[j] | (QB'(ge_u) << BIT);
                q_v_reg[j+1]    <= q_v_reg[j] | (QB'(ge_v) << BIT);
                den_reg[j+1]    <= den_reg[j];
                status_reg[j+1] <= status_reg[j];
            end
        end
    end

    assign out_valid = valid_reg[NS-1];
    assign quot_u    = q_u_reg[QB];
    assign quot_v    = q_v_reg[QB];
    assign status    = status_reg[QB];

endmodule

/* hw/rtl/ppp_sat.sv */
// Output stage: applies sign, saturation and the zero-depth case, holds the result.
// Depends on ppp_pkg for the limits and the status and flag structs.
`timescale 1ns / 1ps

module ppp_sat (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ppp_pkg::QBITS-1:0]     quot_u,
    input  logic [ppp_pkg::QBITS-1:0]     quot_v,
    input  ppp_pkg::ppp_div_status_t      status,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ppp_pkg::PIX_WIDTH-1:0] pixel_u,
    output logic [ppp_pkg::PIX_WIDTH-1:0] pixel_v,
    output ppp_pkg::ppp_flags_t           flags
);

    localparam int PW = ppp_pkg::PIX_WIDTH;
    localparam int QB = ppp_pkg::QBITS;

    function automatic logic [PW:0] clip(input logic [QB-1:0] q, input logic ovf,
                                         input logic neg);
        logic [PW-1:0] pix;
        logic          sat;
        sat = 1'b0;
        if (neg)
        begin
            if (ovf || q > ppp_pkg::Q_NEG_LIMIT)
            begin
                sat = 1'b1;
                pix = ppp_pkg::PIX_MIN_VAL;
            end
            else
            begin
                pix = PW'(~q + 1'b1);
            end
        end
        else
        begin
            if (ovf || q > ppp_pkg::Q_POS_LIMIT)
            begin
                sat = 1'b1;
                pix = ppp_pkg::PIX_MAX_VAL;
            end
            else
            begin
                pix = q[PW-1:0];
            end
        end
        return {sat, pix};
    endfunction

    logic [PW:0]   clip_u, clip_v;
    logic [PW-1:0] pixel_u_reg, pixel_v_reg;
    ppp_pkg::ppp_flags_t flags_reg;
    logic          out_valid_reg;
    logic          load;

    assign clip_u   = clip(quot_u, status.ovf_u, status.neg_u);
    assign clip_v   = clip(quot_v, status.ovf_v, status.neg_v);
    assign in_ready = !out_valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            out_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (status.zero)
            begin
                pixel_u_reg          <= '0;
                pixel_v_reg          <= '0;
                flags_reg.depth_zero <= 1'b1;
                flags_reg.saturated  <= 1'b0;
            end
            else
            begin
                pixel_u_reg          <= clip_u[PW-1:0];
                pixel_v_reg          <= clip_v[PW-1:0];
                flags_reg.depth_zero <= 1'b0;
                flags_reg.saturated  <= clip_u[PW] | clip_v[PW];
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign pixel_u   = pixel_u_reg;
    assign pixel_v   = pixel_v_reg;
    assign flags     = flags_reg;

endmodule

/* hw/rtl/pinhole_point_projection.sv */
// Pinhole projection of homogeneous points through a 3x4 camera matrix.
// Path from input transaction to result: dot product stages, divider stages, then the output register.
// Throughput: one point per cycle while m_tready is not held low; the divider resolves one quotient bit per stage.
// Reset clears all valid bits and the three matrix rows to zero.
// Depends on ppp_pkg, ppp_dot, ppp_div and ppp_sat.
`timescale 1ns / 1ps

module pinhole_point_projection #(
    parameter int COEF_WIDTH  = ppp_pkg::COEF_WIDTH_DEF,
    parameter int COORD_WIDTH = ppp_pkg::COORD_WIDTH_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [ppp_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
    input  logic [ppp_pkg::ROW_WIDTH-1:0]       cfg_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // point_x, point_y, point_z, point_h (16 bits each, from bit 0 up)
    input  logic [63:0]                         s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // pixel_u, pixel_v (16 bits each, from bit 0 up)
    output logic [31:0]                         m_tdata,
    // depth_zero, saturated (from bit 0 up)
    output logic [1:0]                          m_tuser
);

    localparam int S  = COEF_WIDTH + COORD_WIDTH + 2;
    localparam int QB = ppp_pkg::QBITS;
    localparam int PW = ppp_pkg::PIX_WIDTH;

    logic [ppp_pkg::ROW_WIDTH-1:0] row_u_reg, row_v_reg, row_w_reg;

    logic                 dot_valid, dot_ready;
    logic signed [S-1:0]  dot_a, dot_b, dot_c;
    logic                 div_valid, div_ready;
    logic [QB-1:0]        quot_u, quot_v;
    ppp_pkg::ppp_div_status_t div_status;
    logic [PW-1:0]        pixel_u, pixel_v;
    ppp_pkg::ppp_flags_t  flags;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_u_reg <= '0;
            row_v_reg <= '0;
            row_w_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ppp_pkg::REG_ROW_U: row_u_reg <= cfg_data;
                ppp_pkg::REG_ROW_V: row_v_reg <= cfg_data;
                ppp_pkg::REG_ROW_W: row_w_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    ppp_dot #(
        .COEF_WIDTH  (COEF_WIDTH),
        .COORD_WIDTH (COORD_WIDTH),
        .SUM_WIDTH   (S)
    ) u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .row_u     (row_u_reg),
        .row_v     (row_v_reg),
        .row_w     (row_w_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .point     (s_tdata),
        .out_valid (dot_valid),
        .out_ready (dot_ready),
        .dot_a     (dot_a),
        .dot_b     (dot_b),
        .dot_c     (dot_c)
    );

    ppp_div #(
        .SUM_WIDTH (S)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (dot_valid),
        .in_ready  (dot_ready),
        .dot_a     (dot_a),
        .dot_b     (dot_b),
        .dot_c     (dot_c),
        .out_valid (div_valid),
        .out_ready (div_ready),
        .quot_u    (quot_u),
        .quot_v    (quot_v),
        .status    (div_status)
    );

    ppp_sat u_sat (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (div_valid),
        .in_ready  (div_ready),
        .quot_u    (quot_u),
        .quot_v    (quot_v),
        .status    (div_status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .pixel_u   (pixel_u),
        .pixel_v   (pixel_v),
        .flags     (flags)
    );

    assign m_tdata = {pixel_v, pixel_u};
    assign m_tuser = flags;

    a_zero_depth_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && flags.depth_zero |-> m_tdata == '0 && !flags.saturated)
        else $error("zero depth result carries nonzero pixel or saturation");

    a_sat_at_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && flags.saturated |->
            pixel_u == ppp_pkg::PIX_MAX_VAL || pixel_u == ppp_pkg::PIX_MIN_VAL ||
            pixel_v == ppp_pkg::PIX_MAX_VAL || pixel_v == ppp_pkg::PIX_MIN_VAL)
        else $error("saturation flag without a clipped coordinate");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_tvalid |-> s_tready)
        else $error("input stalled while output register is empty");

endmodule

/* sim/ppp_projection_checker.sv */
// Checker for the pinhole point projection block: watches the register port and both streams.
// Predicts each pixel result from its own copy of the camera matrix and compares on output.
// Depends on ppp_pkg.
`timescale 1ns / 1ps

module ppp_projection_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ppp_pkg::CFG_IDX_WIDTH-1:0] cfg_index,
    input  logic [ppp_pkg::ROW_WIDTH-1:0]     cfg_data,
    input  logic                              s_tvalid,
    input  logic                              s_tready,
    input  logic [63:0]                       s_tdata,
    input  logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic [31:0]                       m_tdata,
    input  logic [1:0]                        m_tuser,
    output int                                mismatches,
    output int                                pending,
    output int                                results_out,
    output int                                zero_depth_hits,
    output int                                clip_hits
);

    typedef struct packed {
        logic [15:0] pixel_u;
        logic [15:0] pixel_v;
        logic        depth_zero;
        logic        saturated;
    } pixel_result_t;

    logic [63:0]   row_u;
    logic [63:0]   row_v;
    logic [63:0]   row_w;
    pixel_result_t expected_pixels[$];

    function automatic longint row_dot(input logic [63:0] row, input logic [63:0] pt);
        longint             acc;
        logic signed [15:0] coef;
        logic signed [15:0] coord;
        int                 k;
        acc = 0;
        for (k = 0; k < 4; k++)
        begin
            coef  = row[k*16 +: 16];
            coord = pt[k*16 +: 16];
            acc += longint'(coef) * longint'(coord);
        end
        return acc;
    endfunction

    // Bit 16 of the result marks a clipped quotient.
    function automatic logic [16:0] rounded_ratio(input longint num, input longint den);
        longint unsigned mag_n;
        longint unsigned mag_d;
        longint unsigned quot;
        if (num < 0)
            mag_n = -num;
        else
            mag_n = num;
        if (den < 0)
            mag_d = -den;
        else
            mag_d = den;
        quot = (2 * mag_n + mag_d) / (2 * mag_d);
        if (quot == 0)
            return '0;
        if ((num < 0) != (den < 0))
        begin
            if (quot > 32768)
                return {1'b1, 16'h8000};
            return {1'b0, 16'(-quot)};
        end
        if (quot > 32767)
            return {1'b1, 16'h7FFF};
        return {1'b0, 16'(quot)};
    endfunction

    function automatic pixel_result_t project_point(input logic [63:0] pt);
        pixel_result_t r;
        longint        num_u;
        longint        num_v;
        longint        den;
        logic [16:0]   qu;
        logic [16:0]   qv;
        num_u = row_dot(row_u, pt);
        num_v = row_dot(row_v, pt);
        den   = row_dot(row_w, pt);
        if (den == 0)
        begin
            r.pixel_u    = '0;
            r.pixel_v    = '0;
            r.depth_zero = 1'b1;
            r.saturated  = 1'b0;
            return r;
        end
        qu = rounded_ratio(num_u, den);
        qv = rounded_ratio(num_v, den);
        r.pixel_u    = qu[15:0];
        r.pixel_v    = qv[15:0];
        r.depth_zero = 1'b0;
        r.saturated  = qu[16] | qv[16];
        return r;
    endfunction

    task automatic flag_field(input string field, input int want, input int got);
        mismatches++;
        $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        pixel_result_t       want;
        ppp_pkg::ppp_flags_t flags;
        if (!rst_n)
        begin
            row_u           <= '0;
            row_v           <= '0;
            row_w           <= '0;
            mismatches      = 0;
            pending         = 0;
            results_out     = 0;
            zero_depth_hits = 0;
            clip_hits       = 0;
            expected_pixels.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ppp_pkg::REG_ROW_U: row_u <= cfg_data;
                    ppp_pkg::REG_ROW_V: row_v <= cfg_data;
                    ppp_pkg::REG_ROW_W: row_w <= cfg_data;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                expected_pixels.insert(expected_pixels.size(), project_point(s_tdata));
            if (m_tvalid && m_tready)
            begin
                results_out++;
                flags = m_tuser;
                if (flags.depth_zero === 1'b1)
                    zero_depth_hits++;
                if (flags.saturated === 1'b1)
                    clip_hits++;
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: result transaction with nothing expected, u %0d v %0d",
                             $time, $signed(m_tdata[15:0]), $signed(m_tdata[31:16]));
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (m_tdata[15:0] !== want.pixel_u)
                        flag_field("pixel_u", $signed(want.pixel_u), $signed(m_tdata[15:0]));
                    if (m_tdata[31:16] !== want.pixel_v)
                        flag_field("pixel_v", $signed(want.pixel_v), $signed(m_tdata[31:16]));
                    if (flags.depth_zero !== want.depth_zero)
                        flag_field("depth_zero", want.depth_zero, flags.depth_zero);
                    if (flags.saturated !== want.saturated)
                        flag_field("saturated", want.saturated, flags.saturated);
                end
            end
            pending = expected_pixels.size();
        end
    end

endmodule

/* sim/tb.sv */
// Top of the pinhole point projection regression: clock, reset, stimulus and verdict.
// Drives directed and random points through several camera matrices under random stalls.
// Depends on ppp_pkg, pinhole_point_projection and ppp_projection_checker.
`timescale 1ns / 1ps

module tb;

    localparam int PIPE_LATENCY     = 23;
    localparam int HOLD_CYCLES      = 160;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int RANDOM_PHASES    = 8;
    localparam int POINTS_PER_PHASE = 212;
    localparam int STYLE_CAMERA     = 4;
    localparam logic [ppp_pkg::CFG_IDX_WIDTH-1:0] REG_UNUSED = 2'd3;

    logic                              clk = 1'b0;
    logic                              rst_n;
    logic                              cfg_we;
    logic [ppp_pkg::CFG_IDX_WIDTH-1:0] cfg_index;
    logic [ppp_pkg::ROW_WIDTH-1:0]     cfg_data;
    logic                              s_tvalid;
    logic                              s_tready;
    logic [63:0]                       s_tdata;
    logic                              m_tvalid;
    logic                              m_tready;
    logic [31:0]                       m_tdata;
    logic [1:0]                        m_tuser;

    int mismatches;
    int pending;
    int results_out;
    int zero_depth_hits;
    int clip_hits;
    int points_sent;
    int burst_left;
    int matrix_loads;
    int cycle_count;
    bit hold_req;
    bit hold_active;

    pinhole_point_projection dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    ppp_projection_checker proj_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .mismatches      (mismatches),
        .pending         (pending),
        .results_out     (results_out),
        .zero_depth_hits (zero_depth_hits),
        .clip_hits       (clip_hits)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [63:0] pack_point(input logic [15:0] x, input logic [15:0] y,
                                               input logic [15:0] z, input logic [15:0] h);
        return {h, z, y, x};
    endfunction

    function automatic logic [15:0] pick_coef(input int style);
        case (style)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 8) - 4);
            2: return 16'($urandom_range(0, 4096) - 2048);
            default:
                case ($urandom_range(0, 4))
                    0: return 16'h7FFF;
                    1: return 16'h8000;
                    2: return 16'h0000;
                    3: return 16'hFFFF;
                    default: return 16'h0001;
                endcase
        endcase
    endfunction

    // Lane 0 is row u, 1 row v, 2 row w.
    function automatic logic [63:0] random_row(input int style, input int lane);
        if (style != STYLE_CAMERA)
            return {pick_coef(style), pick_coef(style), pick_coef(style), pick_coef(style)};
        case (lane)
            0: return {16'($urandom), 16'($urandom_range(0, 8000)), 16'h0000,
                       16'($urandom_range(200, 8000))};
            1: return {16'($urandom), 16'($urandom_range(0, 8000)),
                       16'($urandom_range(200, 8000)), 16'h0000};
            default: return {16'($urandom_range(0, 64) - 32), 16'h0010, 32'h0};
        endcase
    endfunction

    // Lane 0..3 is x, y, z, h.
    function automatic logic [15:0] pick_coord(input int style, input int lane);
        case (style)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 8) - 4);
            2:
                case ($urandom_range(0, 4))
                    0: return 16'h8000;
                    1: return 16'hFFFF;
                    2: return 16'h0000;
                    3: return 16'h0001;
                    default: return 16'h7FFF;
                endcase
            default:
                case (lane)
                    0, 1: return 16'($urandom_range(0, 32000) - 16000);
                    2: return 16'($urandom_range(64, 32767));
                    default: return 16'h0100;
                endcase
        endcase
    endfunction

    task automatic offer_point(input logic [63:0] pt);
        s_tdata  <= pt;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (s_tready !== 1'b1)
            @(posedge clk);
        points_sent++;
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                                     : $urandom_range(1, 12);
            if (!(hold_req || hold_active))
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge clk);
            end
        end
    endtask

    task automatic settle();
        if (s_tvalid)
            s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 4) @(posedge clk);
    endtask

    task automatic load_matrix(input logic [63:0] ru, input logic [63:0] rv,
                               input logic [63:0] rw, input bit poke_unused);
        cfg_we    <= 1'b1;
        cfg_index <= ppp_pkg::REG_ROW_U;
        cfg_data  <= ru;
        @(posedge clk);
        cfg_index <= ppp_pkg::REG_ROW_V;
        cfg_data  <= rv;
        @(posedge clk);
        cfg_index <= ppp_pkg::REG_ROW_W;
        cfg_data  <= rw;
        @(posedge clk);
        if (poke_unused)
        begin
            cfg_index <= REG_UNUSED;
            cfg_data  <= {$urandom, $urandom};
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        matrix_loads++;
    endtask

    initial
    begin : drain
        int span;
        int style;
        m_tready    = 1'b0;
        hold_active = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req    = 1'b0;
                hold_active = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_active = 1'b0;
            end
            style = $urandom_range(0, 3);
            span  = $urandom_range(8, 120);
            repeat (span)
            begin
                case (style)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 3) != 0);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ~m_tready;
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("pinhole_point_projection regression: fail");
        $finish;
    end

    initial
    begin
        int          phase;
        int          n;
        int          mstyle;
        int          pstyle;
        logic [63:0] pt;
        rst_n        = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        hold_req     = 1'b0;
        points_sent  = 0;
        burst_left   = 1;
        matrix_loads = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset matrix: every point lands at zero depth
        offer_point(pack_point(16'h0000, 16'h0000, 16'h0000, 16'h0000));
        offer_point(pack_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        offer_point(pack_point(16'h8000, 16'h8000, 16'h8000, 16'h8000));
        settle();

        // u = x / h, v = y / h: ties, signs, zero numerator, zero depth, range ends
        load_matrix(64'h0000_0000_0000_0010, 64'h0000_0000_0010_0000,
                    64'h0010_0000_0000_0000, 1'b0);
        offer_point(pack_point(3, 5, 0, 2));
        offer_point(pack_point(-3, -5, 0, 2));
        offer_point(pack_point(3, -5, 0, -2));
        offer_point(pack_point(0, 0, 9, 7));
        offer_point(pack_point(1, 1, 1, 0));
        offer_point(pack_point(1, 0, 0, 3));
        offer_point(pack_point(2, 0, 0, 3));
        offer_point(pack_point(16'h7FFF, 16'h8000, 0, 1));
        offer_point(pack_point(16'h8000, 16'h7FFF, 0, -1));
        settle();

        // large coefficients: clipping both ways, zero depth from cancelling products
        load_matrix(64'h8000_0000_0000_7FFF, 64'h0000_0000_8000_0000,
                    64'h0001_7FFF_0000_0000, 1'b0);
        offer_point(pack_point(16'h7FFF, 16'h7FFF, 0, 1));
        offer_point(pack_point(16'h8000, 16'h8000, 0, -1));
        offer_point(pack_point(0, 0, 1, 16'h8001));
        offer_point(pack_point(5, -3, 0, 1));
        settle();

        // register extremes; the unused index must leave the matrix alone
        load_matrix(64'hFFFF_FFFF_FFFF_FFFF, 64'h7FFF_7FFF_7FFF_7FFF,
                    64'h8000_8000_8000_8000, 1'b1);
        offer_point(pack_point(1, 2, 3, 4));
        offer_point(pack_point(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000));
        offer_point(pack_point(1, -1, 1, -1));
        offer_point(pack_point(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF));
        settle();

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            mstyle = phase % 5;
            load_matrix(random_row(mstyle, 0), random_row(mstyle, 1), random_row(mstyle, 2),
                        phase == 3);
            for (n = 0; n < POINTS_PER_PHASE; n++)
            begin
                if ((phase == 2 || phase == 5) && n == 40)
                    hold_req = 1'b1;
                if (mstyle == STYLE_CAMERA && $urandom_range(0, 3) != 0)
                    pstyle = 3;
                else
                    pstyle = $urandom_range(0, 3);
                pt = pack_point(pick_coord(pstyle, 0), pick_coord(pstyle, 1),
                                pick_coord(pstyle, 2), pick_coord(pstyle, 3));
                offer_point(pt);
            end
            settle();
        end

        $display("Sent %0d points through %0d camera matrices under random stalls.",
                 points_sent, matrix_loads);
        $display("Got %0d results: %0d at zero depth, %0d clipped, %0d mismatches.",
                 results_out, zero_depth_hits, clip_hits, mismatches);
        if (mismatches == 0)
            $display("pinhole_point_projection regression: pass");
        else
            $display("pinhole_point_projection regression: fail");
        $finish;
    end

endmodule
